FILE: hw/rtl/fixed_point_alu_q24_8_assert.svh
// Assertion macros for the Q24.8 ALU.
`ifndef FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check, skipped while reset is high.
`define FPA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fixed point alu check failed");
// Clocked check that also holds during reset.
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fixed point alu check failed");
`else
`define FPA_ASSERT(lbl, clk, rst, prop)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/fpa_q24_pkg.sv
package fpa_q24_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DATA_W        = 32;
  // Divider: two quotient bits per stage
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = (DATA_W + FRACTION_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QUOT_W     = DIV_STAGES * STEP_BITS;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL  = 4'd2,  CMD_DIV  = 4'd3,
    CMD_GT   = 4'd4,  CMD_LT   = 4'd5,  CMD_GE   = 4'd6,  CMD_LE   = 4'd7,
    CMD_EQ   = 4'd8,  CMD_NE   = 4'd9,  CMD_MIN  = 4'd10, CMD_MAX  = 4'd11,
    CMD_INC  = 4'd12, CMD_DEC  = 4'd13, CMD_FROM = 4'd14, CMD_TO   = 4'd15
  } cmd_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
  } res_t;

  // Word traveling beside the divider
  typedef struct packed {
    logic                     is_div;
    logic                     neg;
    logic                     div_zero;
    logic signed [DATA_W-1:0] value;
    logic                     flag;
    logic [1:0]               status;
  } meta_t;

  // Clamp a signed wide value to the 32-bit range
  function automatic res_t sat_signed(input logic signed [63:0] v);
    res_t r;
    r.status = ST_OK;
    r.value  = v[DATA_W-1:0];
    if (v > 64'(MAX_VAL)) begin
      r.status = ST_SAT;
      r.value  = MAX_VAL;
    end else if (v < 64'(MIN_VAL)) begin
      r.status = ST_SAT;
      r.value  = MIN_VAL;
    end
    return r;
  endfunction

  // Apply a sign to an unsigned magnitude and clamp
  function automatic res_t sat_mag(input logic [63:0] m, input logic neg);
    res_t r;
    r.status = ST_OK;
    r.value  = -m[DATA_W-1:0];
    if (neg) begin
      if (m > {32'd0, MIN_VAL}) begin
        r.status = ST_SAT;
        r.value  = MIN_VAL;
      end
    end else begin
      r.value = m[DATA_W-1:0];
      if (m > {32'd0, MAX_VAL}) begin
        r.status = ST_SAT;
        r.value  = MAX_VAL;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fixed_point_alu_q24_8.sv
// Q24.8 fixed-point ALU. One word enters per cycle and one result word leaves
// per cycle while out_stall does not hold the pipe; every command passes through
// the same registers: stage A, stage B, the divider stages, which retire two quotient
// bits per pipeline stage, and the output register. All stages advance together: when the output word
// is held by out_stall, the whole pipe holds and in_stall rises.
`include "fixed_point_alu_q24_8_assert.svh"
module fixed_point_alu_q24_8 (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          command,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  result,
  output logic                flag,
  output logic [1:0]          status
);

  localparam int DW = fpa_q24_pkg::DATA_W;
  localparam int FB = fpa_q24_pkg::FRACTION_BITS;
  localparam int QW = fpa_q24_pkg::QUOT_W;
  localparam int NS = fpa_q24_pkg::DIV_STAGES;
  localparam int SB = fpa_q24_pkg::STEP_BITS;

  logic advance;

  // Stage A: register operands and their magnitudes
  logic                 a_valid;
  fpa_q24_pkg::cmd_t    a_cmd;
  logic signed [DW-1:0] a_a, a_b;
  logic [DW-1:0]        a_ma, a_mb;
  logic                 a_neg;

  // Stage B: product, dividend, and the simple commands
  logic                 b_valid;
  logic [63:0]          b_prod;
  logic [QW-1:0]        b_dividend;
  logic [DW-1:0]        b_den;
  fpa_q24_pkg::meta_t   b_meta;
  logic                 b_is_mul;
  fpa_q24_pkg::meta_t   b_meta_next;

  // Divider stages; index 0 is the combinational entry
  logic               d_valid [NS+1];
  logic [DW-1:0]      d_rem   [NS+1];
  logic [QW-1:0]      d_work  [NS+1];
  logic [DW-1:0]      d_den   [NS+1];
  fpa_q24_pkg::meta_t d_meta  [NS+1];

  fpa_q24_pkg::res_t  mul_res, div_res;

  // Advance when the output register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
    if (advance) begin
      a_cmd <= fpa_q24_pkg::cmd_t'(command);
      a_a   <= operand_a;
      a_b   <= operand_b;
      a_ma  <= operand_a[DW-1] ? DW'(-operand_a) : operand_a;
      a_mb  <= operand_b[DW-1] ? DW'(-operand_b) : operand_b;
      a_neg <= operand_a[DW-1] ^ operand_b[DW-1];
    end
  end

  // Evaluate the simple commands
  always_comb begin
    logic signed [63:0] ea, eb;
    ea = 64'(a_a);
    eb = 64'(a_b);
    b_meta_next          = '0;
    b_meta_next.neg      = a_neg;
    b_meta_next.is_div   = (a_cmd == fpa_q24_pkg::CMD_DIV);
    b_meta_next.div_zero = (a_b == '0);
    case (a_cmd)
      fpa_q24_pkg::CMD_ADD: {b_meta_next.status, b_meta_next.value} =
                              fpa_q24_pkg::sat_signed(ea + eb);
      fpa_q24_pkg::CMD_SUB: {b_meta_next.status, b_meta_next.value} =
                              fpa_q24_pkg::sat_signed(ea - eb);
      fpa_q24_pkg::CMD_INC: {b_meta_next.status, b_meta_next.value} =
                              fpa_q24_pkg::sat_signed(ea + 64'sd1);
      fpa_q24_pkg::CMD_DEC: {b_meta_next.status, b_meta_next.value} =
                              fpa_q24_pkg::sat_signed(ea - 64'sd1);
      fpa_q24_pkg::CMD_FROM: {b_meta_next.status, b_meta_next.value} =
                              fpa_q24_pkg::sat_signed(ea <<< FB);
      fpa_q24_pkg::CMD_TO:  b_meta_next.value = a_a >>> FB;
      fpa_q24_pkg::CMD_GT:  b_meta_next.flag = (a_a >  a_b);
      fpa_q24_pkg::CMD_LT:  b_meta_next.flag = (a_a <  a_b);
      fpa_q24_pkg::CMD_GE:  b_meta_next.flag = (a_a >= a_b);
      fpa_q24_pkg::CMD_LE:  b_meta_next.flag = (a_a <= a_b);
      fpa_q24_pkg::CMD_EQ:  b_meta_next.flag = (a_a == a_b);
      fpa_q24_pkg::CMD_NE:  b_meta_next.flag = (a_a != a_b);
      fpa_q24_pkg::CMD_MIN: b_meta_next.value = (a_a < a_b) ? a_a : a_b;
      fpa_q24_pkg::CMD_MAX: b_meta_next.value = (a_a > a_b) ? a_a : a_b;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
    if (advance) begin
      b_prod     <= 64'(a_ma) * 64'(a_mb);
      b_dividend <= (QW'(a_ma) << FB) + QW'(a_mb >> 1);
      b_den      <= a_mb;
      b_meta     <= b_meta_next;
      b_is_mul   <= (a_cmd == fpa_q24_pkg::CMD_MUL);
    end
  end

  // Round the product half away from zero and fold it into the word
  assign mul_res = fpa_q24_pkg::sat_mag((b_prod + (64'd1 << (FB - 1))) >> FB, b_meta.neg);

  always_comb begin
    d_valid[0] = b_valid;
    d_rem[0]   = '0;
    d_work[0]  = b_dividend;
    d_den[0]   = b_den;
    d_meta[0]  = b_meta;
    if (b_is_mul) begin
      d_meta[0].status = mul_res.status;
      d_meta[0].value  = mul_res.value;
    end
  end

  // Restoring divider: shift in dividend bits, shift out quotient bits
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [DW-1:0] rem_next;
    logic [QW-1:0] work_next;

    always_comb begin
      logic [DW:0] trial;
      rem_next  = d_rem[k];
      work_next = d_work[k];
      for (int s = 0; s < SB; s++) begin
        trial     = {rem_next, work_next[QW-1]};
        work_next = {work_next[QW-2:0], 1'b0};
        if (trial >= {1'b0, d_den[k]}) begin
          trial        = trial - {1'b0, d_den[k]};
          work_next[0] = 1'b1;
        end
        rem_next = trial[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (advance) begin
        d_valid[k+1] <= d_valid[k];
      end
      if (advance) begin
        d_rem[k+1]  <= rem_next;
        d_work[k+1] <= work_next;
        d_den[k+1]  <= d_den[k];
        d_meta[k+1] <= d_meta[k];
      end
    end
  end

  assign div_res = fpa_q24_pkg::sat_mag(64'(d_work[NS]), d_meta[NS].neg);

  // Output register: pick the divider result, zero on a divide by zero, or the carried word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= d_valid[NS];
    end
    if (advance) begin
      if (d_meta[NS].is_div && d_meta[NS].div_zero) begin
        result <= '0;
        flag   <= 1'b0;
        status <= fpa_q24_pkg::ST_DZ;
      end else if (d_meta[NS].is_div) begin
        result <= div_res.value;
        flag   <= 1'b0;
        status <= div_res.status;
      end else begin
        result <= d_meta[NS].value;
        flag   <= d_meta[NS].flag;
        status <= d_meta[NS].status;
      end
    end
  end

  `FPA_ASSERT(a_dz_zero, clk, rst, out_valid && status == fpa_q24_pkg::ST_DZ |-> result == '0)
  `FPA_ASSERT(a_flag_clean, clk, rst, out_valid && flag |-> result == '0 && status == fpa_q24_pkg::ST_OK)
  `FPA_ASSERT(a_sat_bound, clk, rst, out_valid && status == fpa_q24_pkg::ST_SAT |-> result == fpa_q24_pkg::MAX_VAL || result == fpa_q24_pkg::MIN_VAL)
  `FPA_ASSERT_ALWAYS(a_status_code, clk, rst || !out_valid || status <= fpa_q24_pkg::ST_DZ)

endmodule
